### sv/sit_pkg.sv
// Shared constants, codes and controller/datapath interface types for the sorted table.
`timescale 1ns / 1ps
package sit_pkg;

  localparam int DEPTH    = 32;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 6;
  localparam int OP_W     = 2;
  localparam int S_DATA_W = 32;
  localparam int M_DATA_W = 40;
  localparam int M_USER_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef struct packed {
    logic accept;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic start_read;
    logic rd_last;
    logic slot_free;
  } dp_status_t;

endpackage

### sv/sorted_insert_table_top.sv
// Sorted insertion table: accepts insert, readout and clear transactions and streams results.
// Insert, clear, no-op and empty readout each give one result, registered in the cycle after acceptance.
// A readout of N entries gives N results, one per cycle while the output is not stalled, once the
// controller has entered its read state. Input is taken at one transaction per cycle while the output
// is not stalled, except that a readout holds off input while the read index walks the cell row.
// Synchronous active-high reset empties the table and the output register.
`timescale 1ns / 1ps
module sorted_insert_table_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [sit_pkg::S_DATA_W-1:0]  s_tdata,  // value[31:0]
  input  logic [sit_pkg::OP_W-1:0]      s_tuser,  // op[1:0]
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [sit_pkg::M_DATA_W-1:0]  m_tdata,  // entry[31:0], count[37:32], zero pad
  output logic [sit_pkg::M_USER_W-1:0]  m_tuser,  // dropped[0], empty_res[1]
  output logic                          m_tlast
);
  import sit_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  sit_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd),
    .status   (status)
  );

  sit_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cmd      (cmd),
    .status   (status),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

### sv/sit_ctrl.sv
// Controller state machine that sequences transactions and readout for the sorted table.
`timescale 1ns / 1ps
module sit_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  output sit_pkg::ctrl_cmd_t  cmd,
  input  sit_pkg::dp_status_t status
);
  import sit_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  assign s_tready   = (state == ST_IDLE) && status.slot_free;
  assign cmd.accept = s_tvalid && s_tready;
  assign cmd.emit   = (state == ST_READ) && status.slot_free;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.accept && status.start_read) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        if (cmd.emit && status.rd_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### sv/sit_datapath.sv
// Datapath with the compare-and-shift cell row, entry count, read index and output register.
`timescale 1ns / 1ps
module sit_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [sit_pkg::S_DATA_W-1:0]  s_tdata,
  input  logic [sit_pkg::OP_W-1:0]      s_tuser,
  input  sit_pkg::ctrl_cmd_t            cmd,
  output sit_pkg::dp_status_t           status,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [sit_pkg::M_DATA_W-1:0]  m_tdata,
  output logic [sit_pkg::M_USER_W-1:0]  m_tuser,
  output logic                          m_tlast
);
  import sit_pkg::*;

  logic signed [VALUE_W-1:0] cells [DEPTH];
  logic signed [VALUE_W-1:0] cells_next [DEPTH];
  logic        [DEPTH-1:0]   lt;
  logic        [CNT_W-1:0]   count;
  logic        [IDX_W-1:0]   rd_idx;
  logic signed [VALUE_W-1:0] value;
  op_t                       op;
  logic                      full;
  logic                      do_insert;
  logic                      load_single;
  logic                      load;

  logic signed [VALUE_W-1:0] out_entry;
  logic                      out_last;
  logic                      out_dropped;
  logic                      out_empty;
  logic        [CNT_W-1:0]   out_count;

  logic signed [VALUE_W-1:0] res_entry;
  logic                      res_last;
  logic                      res_dropped;
  logic                      res_empty;
  logic        [CNT_W-1:0]   res_count;

  assign value = $signed(s_tdata[VALUE_W-1:0]);
  assign op    = op_t'(s_tuser);
  assign full  = (count == CNT_W'(DEPTH));

  assign status.slot_free  = !m_tvalid || m_tready;
  assign status.start_read = (op == OP_READ) && (count != '0);
  assign status.rd_last    = (CNT_W'(rd_idx) == count - CNT_W'(1));

  assign do_insert   = cmd.accept && (op == OP_INSERT) && !full;
  assign load_single = cmd.accept && !status.start_read;
  assign load        = load_single || cmd.emit;

  // Each cell compares against the new value; the ordered contents make lt a prefix.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      lt[i] = (CNT_W'(i) < count) && (cells[i] < value);
    end
    cells_next[0] = lt[0] ? cells[0] : value;
    for (int i = 1; i < DEPTH; i++) begin
      if (lt[i]) begin
        cells_next[i] = cells[i];
      end else if (lt[i-1]) begin
        cells_next[i] = value;
      end else begin
        cells_next[i] = cells[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_insert) begin
      for (int i = 0; i < DEPTH; i++) begin
        cells[i] <= cells_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (do_insert) begin
      count <= count + CNT_W'(1);
    end else if (cmd.accept && (op == OP_CLEAR)) begin
      count <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx <= '0;
    end else if (cmd.accept) begin
      rd_idx <= '0;
    end else if (cmd.emit) begin
      rd_idx <= rd_idx + IDX_W'(1);
    end
  end

  always_comb begin
    res_entry   = '0;
    res_last    = 1'b1;
    res_dropped = 1'b0;
    res_empty   = 1'b0;
    res_count   = count;
    if (cmd.emit) begin
      res_entry = cells[rd_idx];
      res_last  = status.rd_last;
    end else begin
      unique case (op)
        OP_INSERT: begin
          if (full) begin
            res_dropped = 1'b1;
          end else begin
            res_count = count + CNT_W'(1);
          end
        end
        OP_READ: begin
          res_empty = 1'b1;
          res_count = '0;
        end
        OP_CLEAR: begin
          res_count = '0;
        end
        default: begin
          res_count = count;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_entry   <= res_entry;
      out_last    <= res_last;
      out_dropped <= res_dropped;
      out_empty   <= res_empty;
      out_count   <= res_count;
    end
  end

  assign m_tdata = {(M_DATA_W - VALUE_W - COUNT_W)'(0), out_count[COUNT_W-1:0],
                    out_entry};
  assign m_tuser = {out_empty, out_dropped};
  assign m_tlast = out_last;

endmodule
